@@ design/csma_ca_backoff_controller_macros.svh @@
// ---------------------------------------------------------------------------
// CSMA/CA backoff controller assertion macros
// Shared concurrent assertion forms for the controller modules.
// ---------------------------------------------------------------------------
`ifndef CSMA_CA_BACKOFF_CONTROLLER_MACROS_SVH
`define CSMA_CA_BACKOFF_CONTROLLER_MACROS_SVH

// Property that must hold at every edge outside reset.
`define CBO_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("cbo assertion failed");

// Consequent that must hold after the antecedent, as a non-overlapping implication.
`define CBO_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cbo assertion failed");

`endif

@@ design/cbo_pkg.sv @@
// ---------------------------------------------------------------------------
// CSMA/CA backoff controller package
// Payload types, configuration type and shared codes.
// ---------------------------------------------------------------------------
package cbo_pkg;

  typedef struct packed {
    logic        packet_waiting;
    logic        medium_busy;
    logic        collision_seen;
    logic [15:0] random_draw;
  } in_item_t;

  typedef struct packed {
    logic        tx_attempt;
    logic [1:0]  outcome;
    logic [3:0]  stage_now;
    logic [4:0]  retries_now;
    logic [11:0] window_left;
    logic [1:0]  phase_now;
  } out_item_t;

  typedef struct packed {
    logic [3:0] difs_slots;
    logic [3:0] retry_limit;
    logic [3:0] stage_limit;
  } cbo_cfg_t;

  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_DIFS_SLOTS  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_RETRY_LIMIT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_STAGE_LIMIT = 2'd2;

  localparam logic [3:0] DIFS_SLOTS_RST  = 4'd5;
  localparam logic [3:0] RETRY_LIMIT_RST = 4'd7;
  localparam logic [3:0] STAGE_LIMIT_RST = 4'd5;

  localparam logic [1:0] OC_NONE    = 2'd0;
  localparam logic [1:0] OC_SENT    = 2'd1;
  localparam logic [1:0] OC_RETRY   = 2'd2;
  localparam logic [1:0] OC_DROPPED = 2'd3;

endpackage

@@ design/cbo_window.sv @@
// ---------------------------------------------------------------------------
// CSMA/CA backoff window draw
// Scales a random draw by the stage window span to a slot count.
// ---------------------------------------------------------------------------
module cbo_window import cbo_pkg::*; #(
  parameter int unsigned MAX_STAGE = 10,
  parameter int unsigned DRAW_BITS = 16
) (
  input  logic [15:0] draw_i,
  input  logic [3:0]  stage_i,
  output logic [11:0] count_o
);

  localparam int unsigned DrawW    = (DRAW_BITS < 16) ? DRAW_BITS : 16;
  localparam logic [15:0] DrawMask = 16'((33'd1 << DrawW) - 33'd1);
  localparam logic [3:0]  MaxStage = 4'(MAX_STAGE);

  logic [3:0]  stage_c;
  logic [11:0] span;
  logic [27:0] prod;

  assign stage_c = (stage_i > MaxStage) ? MaxStage : stage_i;
  assign span    = 12'((13'd1 << (stage_c + 4'd2)) - 13'd1);
  assign prod    = 28'(draw_i & DrawMask) * 28'(span);
  assign count_o = 12'(prod >> DRAW_BITS) + 12'd1;

endmodule

@@ design/cbo_core.sv @@
// ---------------------------------------------------------------------------
// CSMA/CA backoff controller core
// Per-tick access state machine: DIFS wait, countdown, transmit, retries.
// ---------------------------------------------------------------------------
`include "csma_ca_backoff_controller_macros.svh"

module cbo_core import cbo_pkg::*; #(
  parameter int unsigned MAX_STAGE = 10,
  parameter int unsigned DRAW_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  input  cbo_cfg_t  cfg_i,
  output out_item_t result_o
);

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_DIFS    = 2'd1,
    PH_BACKOFF = 2'd2,
    PH_TX      = 2'd3
  } phase_e;

  localparam logic [3:0] MaxStage = 4'(MAX_STAGE);

  phase_e      phase_q, phase_d;
  logic [3:0]  idle_q, idle_d;
  logic [11:0] win_q, win_d;
  logic        wvalid_q, wvalid_d;
  logic [3:0]  stage_q, stage_d;
  logic [4:0]  retry_q, retry_d;
  logic        first_q, first_d;

  logic [11:0] draw_count;
  logic [3:0]  need;
  logic [3:0]  eff_limit;
  logic        tx;
  logic [1:0]  oc;

  cbo_window #(
    .MAX_STAGE(MAX_STAGE),
    .DRAW_BITS(DRAW_BITS)
  ) u_window (
    .draw_i (item_i.random_draw),
    .stage_i(stage_q),
    .count_o(draw_count)
  );

  assign need      = (cfg_i.difs_slots == 4'd0) ? 4'd1 : cfg_i.difs_slots;
  assign eff_limit = (cfg_i.stage_limit > MaxStage) ? MaxStage : cfg_i.stage_limit;

  always_comb begin
    phase_d  = phase_q;
    idle_d   = idle_q;
    win_d    = win_q;
    wvalid_d = wvalid_q;
    stage_d  = stage_q;
    retry_d  = retry_q;
    first_d  = first_q;
    tx       = 1'b0;
    oc       = OC_NONE;

    if (phase_q == PH_IDLE && item_i.packet_waiting) begin
      phase_d = PH_DIFS;
      idle_d  = '0;
    end

    unique case (phase_d)
      PH_DIFS: begin
        if (!item_i.packet_waiting) begin
          phase_d = PH_IDLE;
          idle_d  = '0;
        end else if (item_i.medium_busy) begin
          idle_d  = '0;
          first_d = 1'b1;
        end else begin
          idle_d = idle_d + 4'd1;
          if (idle_d >= need) begin
            idle_d = '0;
            if (!first_q) begin
              phase_d = PH_TX;
            end else begin
              if (!wvalid_q) begin
                win_d    = draw_count;
                wvalid_d = 1'b1;
              end
              phase_d = PH_BACKOFF;
            end
          end
        end
      end
      PH_BACKOFF: begin
        if (!item_i.packet_waiting) begin
          phase_d = PH_IDLE;
          idle_d  = '0;
        end else if (item_i.medium_busy) begin
          phase_d = PH_DIFS;
          idle_d  = '0;
        end else begin
          if (win_d != 12'd0) win_d = win_d - 12'd1;
          if (win_d == 12'd0) phase_d = PH_TX;
        end
      end
      PH_TX: begin
        tx = 1'b1;
        if (item_i.collision_seen) begin
          retry_d = retry_q + 5'd1;
          if (first_q) stage_d = stage_q + 4'd1;
          if (stage_d > eff_limit) stage_d = eff_limit;
          if (retry_d > {1'b0, cfg_i.retry_limit}) begin
            retry_d = '0;
            stage_d = '0;
            oc      = OC_DROPPED;
            phase_d = PH_IDLE;
          end else begin
            oc      = OC_RETRY;
            phase_d = PH_DIFS;
          end
        end else begin
          retry_d = '0;
          stage_d = '0;
          oc      = OC_SENT;
          phase_d = PH_IDLE;
        end
        first_d  = 1'b1;
        win_d    = '0;
        wvalid_d = 1'b0;
        idle_d   = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result_o.tx_attempt  = tx;
    result_o.outcome     = oc;
    result_o.stage_now   = stage_d;
    result_o.retries_now = retry_d;
    result_o.window_left = wvalid_d ? win_d : 12'd0;
    result_o.phase_now   = phase_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      idle_q   <= '0;
      win_q    <= '0;
      wvalid_q <= 1'b0;
      stage_q  <= '0;
      retry_q  <= '0;
      first_q  <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      idle_q   <= idle_d;
      win_q    <= win_d;
      wvalid_q <= wvalid_d;
      stage_q  <= stage_d;
      retry_q  <= retry_d;
      first_q  <= first_d;
    end
  end

  `CBO_ASSERT(a_backoff_has_window, clk_i, rst_ni, (phase_q != PH_BACKOFF) || wvalid_q)
  `CBO_ASSERT(a_stage_bounded, clk_i, rst_ni, stage_q <= MaxStage)
  `CBO_ASSERT_NEXT(a_tx_sets_first, clk_i, rst_ni, step_i && (phase_q == PH_TX), first_q && !wvalid_q)

endmodule

@@ design/csma_ca_backoff_controller.sv @@
// ---------------------------------------------------------------------------
// CSMA/CA backoff controller
// Slot-tick access controller with binary exponential backoff.
// ---------------------------------------------------------------------------
// Input channel: one slot tick per transfer (packet waiting, medium busy,
// collision, random draw). Output channel: one result per tick with the
// transmit flag, outcome, stage, retry count, window left and phase.
// A tick passes an input register and then a result register, from which
// its result can transfer once the receiver does not stall.
// One tick per cycle is sustained while the receiver does not stall;
// the per-tick state update is a single pass of logic on the input register.
// The window draw is one 16 x 12 multiply in that pass.
// When the receiver stalls, the result register holds; a further tick waits
// in the input register and the input stalls only when both are occupied.
// Configuration writes are registered and must be done while no tick is
// in flight. Reset restores the default registers (DIFS 5, retry limit 7,
// stage limit 5), clears all access state and empties both registers.
// ---------------------------------------------------------------------------
`include "csma_ca_backoff_controller_macros.svh"

module csma_ca_backoff_controller import cbo_pkg::*; #(
  parameter int unsigned MAX_STAGE = 10,
  parameter int unsigned DRAW_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [3:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_item_o
);

  cbo_cfg_t  cfg_q;
  logic      in_valid_q, in_valid_d;
  in_item_t  in_item_q;
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q;
  out_item_t result;
  logic      advance;
  logic      accept;
  logic      step;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;
  assign step       = in_valid_q && advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (advance) in_valid_d = 1'b0;
    if (accept) in_valid_d = 1'b1;
    out_valid_d = out_valid_q;
    if (advance) out_valid_d = in_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.difs_slots  <= DIFS_SLOTS_RST;
      cfg_q.retry_limit <= RETRY_LIMIT_RST;
      cfg_q.stage_limit <= STAGE_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_DIFS_SLOTS:  cfg_q.difs_slots  <= cfg_wdata_i;
        CFG_RETRY_LIMIT: cfg_q.retry_limit <= cfg_wdata_i;
        CFG_STAGE_LIMIT: cfg_q.stage_limit <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) in_item_q <= in_item_i;
    if (step) out_item_q <= result;
  end

  cbo_core #(
    .MAX_STAGE(MAX_STAGE),
    .DRAW_BITS(DRAW_BITS)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .item_i  (in_item_q),
    .cfg_i   (cfg_q),
    .result_o(result)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `CBO_ASSERT(a_stall_needs_item, clk_i, rst_ni, !in_stall_o || (in_valid_q && out_valid_q))
  `CBO_ASSERT_NEXT(a_accept_fills, clk_i, rst_ni, accept, in_valid_q)
  `CBO_ASSERT_NEXT(a_step_fills_out, clk_i, rst_ni, step, out_valid_q)

endmodule

@@ verif/tb_csma_ca_backoff_controller.sv @@
// ---------------------------------------------------------------------------
// CSMA/CA backoff controller testbench
// Drives slot ticks through the valid/stall input channel and checks every
// result against an in-bench model of the access state machine or, where a
// row gives one, the expected result of a short directed table. The table
// covers the first attempt, busy slots, drops and sends. It is followed by
// random phases under several register settings and idle mixes.
module tb_csma_ca_backoff_controller;
  timeunit 1ns;
  timeprecision 1ps;

  import cbo_pkg::*;

  typedef enum logic [1:0] {ACC_IDLE, ACC_DIFS, ACC_BACKOFF, ACC_TX} acc_phase_e;

  typedef struct {
    in_item_t  tick;
    bit        has_want;
    out_item_t want;
  } slot_row_t;

  localparam int unsigned STAGE_CAP   = 10;
  localparam int unsigned NUM_PHASES  = 6;
  localparam int unsigned PHASE_TICKS = 330;
  localparam int unsigned NUM_ROWS    = 21;
  localparam out_item_t   NO_WANT     = '0;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = CFG_DIFS_SLOTS;
  logic [3:0]   cfg_wdata = '0;
  logic         in_valid = 1'b0;
  logic         in_stall;
  in_item_t     in_item = '0;
  logic         out_valid;
  logic         out_stall = 1'b0;
  out_item_t    out_item;

  // Model state and registers
  logic [3:0]   difs_cfg = DIFS_SLOTS_RST;
  logic [3:0]   retry_cfg = RETRY_LIMIT_RST;
  logic [3:0]   stage_cfg = STAGE_LIMIT_RST;
  acc_phase_e   acc_phase = ACC_IDLE;
  logic [3:0]   idle_slots = '0;
  logic [11:0]  window_cnt = '0;
  logic         window_armed = 1'b0;
  logic [3:0]   stage = '0;
  logic [4:0]   retries = '0;
  logic         first_sent = 1'b0;

  out_item_t    due_slot_results[$];
  int unsigned  mismatch_count = 0;
  int unsigned  send_gap_pct = 0;
  int unsigned  recv_stall_pct = 0;
  int unsigned  hold_off_cycles = 0;

  slot_row_t directed_rows [NUM_ROWS] = '{
    '{'{1'b0, 1'b0, 1'b0, 16'h0000}, 1'b1, '{1'b0, OC_NONE, 4'd0, 5'd0, 12'd0, ACC_IDLE}},
    '{'{1'b1, 1'b0, 1'b0, 16'h0000}, 1'b1, '{1'b0, OC_NONE, 4'd0, 5'd0, 12'd0, ACC_TX}},
    '{'{1'b0, 1'b0, 1'b1, 16'h0000}, 1'b1, '{1'b1, OC_RETRY, 4'd0, 5'd1, 12'd0, ACC_DIFS}},
    '{'{1'b1, 1'b1, 1'b0, 16'h0000}, 1'b0, NO_WANT},
    '{'{1'b1, 1'b0, 1'b0, 16'hFFFF}, 1'b0, NO_WANT},
    '{'{1'b1, 1'b1, 1'b0, 16'h0000}, 1'b0, NO_WANT},
    '{'{1'b0, 1'b0, 1'b0, 16'h0000}, 1'b0, NO_WANT},
    '{'{1'b1, 1'b0, 1'b0, 16'h0000}, 1'b0, NO_WANT},
    '{'{1'b1, 1'b0, 1'b0, 16'h0000}, 1'b0, NO_WANT},
    '{'{1'b1, 1'b0, 1'b0, 16'h0000}, 1'b0, NO_WANT},
    '{'{1'b1, 1'b0, 1'b0, 16'h0000}, 1'b0, NO_WANT},
    '{'{1'b1, 1'b0, 1'b1, 16'h0000}, 1'b1, '{1'b1, OC_DROPPED, 4'd0, 5'd0, 12'd0, ACC_IDLE}},
    '{'{1'b1, 1'b0, 1'b0, 16'h0000}, 1'b0, NO_WANT},
    '{'{1'b1, 1'b0, 1'b0, 16'h0000}, 1'b0, NO_WANT},
    '{'{1'b1, 1'b0, 1'b0, 16'h0000}, 1'b1, '{1'b1, OC_SENT, 4'd0, 5'd0, 12'd0, ACC_IDLE}},
    '{'{1'b1, 1'b0, 1'b1, 16'h8000}, 1'b0, NO_WANT},
    '{'{1'b1, 1'b0, 1'b0, 16'h0000}, 1'b0, NO_WANT},
    '{'{1'b1, 1'b0, 1'b0, 16'h0000}, 1'b0, NO_WANT},
    '{'{1'b1, 1'b0, 1'b1, 16'h0000}, 1'b0, NO_WANT},
    '{'{1'b1, 1'b0, 1'b0, 16'hFFFF}, 1'b0, NO_WANT},
    '{'{1'b0, 1'b1, 1'b1, 16'hFFFF}, 1'b0, NO_WANT}
  };

  logic [3:0] set_difs  [NUM_PHASES] = '{4'd1,  4'd15, 4'd0,  4'd2, 4'd3,  4'd1};
  logic [3:0] set_retry [NUM_PHASES] = '{4'd15, 4'd0,  4'd3,  4'd7, 4'd15, 4'd2};
  logic [3:0] set_stage [NUM_PHASES] = '{4'd10, 4'd0,  4'd15, 4'd5, 4'd15, 4'd10};

  csma_ca_backoff_controller dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [11:0] backoff_window(input logic [3:0] st_in,
                                                 input logic [15:0] draw);
    int unsigned st;
    logic [27:0] span;
    logic [27:0] prod;
    st = (st_in > STAGE_CAP) ? STAGE_CAP : st_in;
    span = 28'((32'd1 << (st + 2)) - 32'd1);
    prod = 28'(draw) * span;
    return 12'(28'd1 + (prod >> 16));
  endfunction

  function automatic out_item_t next_slot_result(input in_item_t t);
    out_item_t r;
    logic [3:0] need;
    logic [3:0] stage_top;
    r = '0;
    r.outcome = OC_NONE;
    need = (difs_cfg == 4'd0) ? 4'd1 : difs_cfg;
    stage_top = (stage_cfg > STAGE_CAP) ? 4'(STAGE_CAP) : stage_cfg;
    if (acc_phase == ACC_IDLE && t.packet_waiting) begin
      acc_phase = ACC_DIFS;
      idle_slots = '0;
    end
    case (acc_phase)
      ACC_DIFS: begin
        if (!t.packet_waiting) begin
          acc_phase = ACC_IDLE;
          idle_slots = '0;
        end else if (t.medium_busy) begin
          idle_slots = '0;
          first_sent = 1'b1;
        end else begin
          idle_slots = idle_slots + 4'd1;
          if (idle_slots >= need) begin
            idle_slots = '0;
            if (!first_sent) begin
              acc_phase = ACC_TX;
            end else begin
              if (!window_armed) begin
                window_cnt = backoff_window(stage, t.random_draw);
                window_armed = 1'b1;
              end
              acc_phase = ACC_BACKOFF;
            end
          end
        end
      end
      ACC_BACKOFF: begin
        if (!t.packet_waiting) begin
          acc_phase = ACC_IDLE;
          idle_slots = '0;
        end else if (t.medium_busy) begin
          acc_phase = ACC_DIFS;
          idle_slots = '0;
        end else begin
          if (window_cnt != '0) window_cnt = window_cnt - 12'd1;
          if (window_cnt == '0) acc_phase = ACC_TX;
        end
      end
      ACC_TX: begin
        r.tx_attempt = 1'b1;
        if (t.collision_seen) begin
          retries = retries + 5'd1;
          if (first_sent) stage = stage + 4'd1;
          if (stage > stage_top) stage = stage_top;
          if (retries > {1'b0, retry_cfg}) begin
            retries = '0;
            stage = '0;
            r.outcome = OC_DROPPED;
            acc_phase = ACC_IDLE;
          end else begin
            r.outcome = OC_RETRY;
            acc_phase = ACC_DIFS;
          end
        end else begin
          retries = '0;
          stage = '0;
          r.outcome = OC_SENT;
          acc_phase = ACC_IDLE;
        end
        first_sent = 1'b1;
        window_cnt = '0;
        window_armed = 1'b0;
        idle_slots = '0;
      end
      default: ;
    endcase
    r.stage_now = stage;
    r.retries_now = retries;
    r.window_left = window_armed ? window_cnt : 12'd0;
    r.phase_now = acc_phase;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_slot_result(input out_item_t got);
    out_item_t want;
    if (due_slot_results.size() == 0) begin
      report_mismatch($sformatf("result %h with no tick outstanding", got));
      return;
    end
    want = due_slot_results.pop_front();
    if (got.tx_attempt !== want.tx_attempt)
      report_mismatch($sformatf("tx_attempt %h, want %h", got.tx_attempt, want.tx_attempt));
    if (got.outcome !== want.outcome)
      report_mismatch($sformatf("outcome %h, want %h", got.outcome, want.outcome));
    if (got.stage_now !== want.stage_now)
      report_mismatch($sformatf("stage_now %0d, want %0d", got.stage_now, want.stage_now));
    if (got.retries_now !== want.retries_now)
      report_mismatch($sformatf("retries_now %0d, want %0d", got.retries_now,
                                want.retries_now));
    if (got.window_left !== want.window_left)
      report_mismatch($sformatf("window_left %0d, want %0d", got.window_left,
                                want.window_left));
    if (got.phase_now !== want.phase_now)
      report_mismatch($sformatf("phase_now %0d, want %0d", got.phase_now, want.phase_now));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_slot_result(out_item);
  end

  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        out_stall <= 1'b1;
        hold_off_cycles--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_tick(input in_item_t t, input bit has_want, input out_item_t want);
    out_item_t predicted;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= t;
    do @(posedge clk); while (in_stall);
    predicted = next_slot_result(t);
    if (has_want) predicted = want;
    due_slot_results = {due_slot_results, predicted};
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (due_slot_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apply_setting(input logic [3:0] difs, input logic [3:0] retry,
                               input logic [3:0] stage_lim);
    cfg_we <= 1'b1;
    cfg_index <= CFG_DIFS_SLOTS;
    cfg_wdata <= difs;
    @(negedge clk);
    cfg_index <= CFG_RETRY_LIMIT;
    cfg_wdata <= retry;
    @(negedge clk);
    cfg_index <= CFG_STAGE_LIMIT;
    cfg_wdata <= stage_lim;
    @(negedge clk);
    cfg_we <= 1'b0;
    difs_cfg = difs;
    retry_cfg = retry;
    stage_cfg = stage_lim;
  endtask

  function automatic in_item_t random_tick();
    in_item_t t;
    if ($urandom_range(9) == 0) begin
      t = 19'($urandom);
    end else begin
      t.packet_waiting = ($urandom_range(24) != 0);
      t.medium_busy = ($urandom_range(6) == 0);
      t.collision_seen = 1'($urandom_range(1));
      case ($urandom_range(9))
        0: t.random_draw = 16'h0000;
        1: t.random_draw = 16'hFFFF;
        default: t.random_draw = 16'($urandom);
      endcase
    end
    return t;
  endfunction

  initial begin
    #3_000_000;
    $display("tb_csma_ca_backoff_controller NOT OK");
    $finish;
  end

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_gap_pct = 20;
    recv_stall_pct = 79;
    send_tick(directed_rows[0].tick, directed_rows[0].has_want, directed_rows[0].want);
    drain_results();
    apply_setting(4'd1, 4'd1, 4'd2);
    for (int i = 1; i < NUM_ROWS; i++) begin
      send_tick(directed_rows[i].tick, directed_rows[i].has_want, directed_rows[i].want);
    end
    drain_results();

    for (int p = 0; p < NUM_PHASES; p++) begin
      apply_setting(set_difs[p], set_retry[p], set_stage[p]);
      if (p < 2) begin
        send_gap_pct = 20;
        recv_stall_pct = 79;
      end else if (p < 4) begin
        send_gap_pct = 79;
        recv_stall_pct = 20;
      end else begin
        send_gap_pct = 0;
        recv_stall_pct = 0;
      end
      for (int n = 0; n < PHASE_TICKS; n++) begin
        if (p == 4 && n == 150) drain_results();
        if (p == 5 && n == 100) hold_off_cycles = 40;
        send_tick(random_tick(), 1'b0, NO_WANT);
      end
      drain_results();
    end

    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_csma_ca_backoff_controller OK");
    end else begin
      $display("tb_csma_ca_backoff_controller NOT OK");
    end
    $finish;
  end

endmodule
